// File: sv/mpsm_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-pattern string matcher core.
// Holds transaction structs, command codes, FSM states and defaults; no dependencies.
package mpsm_pkg;

  localparam int unsigned MaxNodesDef    = 256;
  localparam int unsigned SymbolBitsDef  = 8;
  localparam int unsigned MaxPatternsDef = 256;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_BUILD   = 3'd1,
    CMD_SCAN    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] symbol;
    logic       last_of_pattern;
  } req_t;

  typedef struct packed {
    logic [7:0] current_node;
    logic       is_match;
    logic [7:0] pattern_index;
    logic       status;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_G,
    ST_SCAN_RD,
    ST_SCAN_G,
    ST_SCAN_F,
    ST_MARK_RD,
    ST_RESP,
    ST_BR_RD,
    ST_BR_G,
    ST_BQ_CHK,
    ST_BQ_U,
    ST_BQ_FU,
    ST_BC_RD,
    ST_BC_V,
    ST_BF_CHK,
    ST_BF_G,
    ST_BF_F
  } state_e;

endpackage

// File: sv/multi_pattern_string_matcher_core.sv
`timescale 1ns / 1ps
// Aho-Corasick matcher: goto, failure, mark and walk-queue memories plus one control FSM.
// Depends on mpsm_pkg.
// Add reads the goto entry, then the mark entry; scan also follows failure links; restart/unused answer from idle.
// Build: root symbols first, then per queued node each symbol, each child and each failure-link hop.
// Clear and reset sweep the goto memory with busy_o high.
// One transaction at a time; done_o marks each result for one cycle, receiver cannot stall.
module multi_pattern_string_matcher_core import mpsm_pkg::*; #(
  parameter int unsigned MAX_NODES    = MaxNodesDef,
  parameter int unsigned SYMBOL_BITS  = SymbolBitsDef,
  parameter int unsigned MAX_PATTERNS = MaxPatternsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned SB = SYMBOL_BITS;
  localparam int unsigned PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned GA = NW + SB;
  localparam int unsigned GDEPTH = 1 << GA;
  localparam logic [NW:0] MaxCnt = (NW+1)'(MAX_NODES);
  localparam logic [PW-1:0] LastPat = PW'(MAX_PATTERNS - 1);

  logic [NW-1:0] goto_mem [GDEPTH];
  logic [NW-1:0] fail_mem [MAX_NODES];
  logic [PW:0]   mark_mem [MAX_NODES];
  logic [NW-1:0] queue_mem [MAX_NODES];

  logic          g_we, f_we, m_we, q_we;
  logic [GA-1:0] g_waddr, g_raddr;
  logic [NW-1:0] g_wdata, g_rdata_q;
  logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata_q;
  logic [NW-1:0] m_waddr, m_raddr;
  logic [PW:0]   m_wdata, m_rdata_q;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      goto_mem[g_waddr] <= g_wdata;
    end
    g_rdata_q <= goto_mem[g_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fail_mem[f_waddr] <= f_wdata;
    end
    f_rdata_q <= fail_mem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mark_mem[m_waddr] <= m_wdata;
    end
    m_rdata_q <= mark_mem[m_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= queue_mem[q_raddr];
  end

  state_e        state_q, state_d;
  logic [SB-1:0] sym_q, sym_d, c_q, c_d;
  logic          last_q, last_d, status_q, status_d;
  logic [NW-1:0] node_q, node_d, v_q, v_d, f_q, f_d, fu_q, fu_d;
  logic [NW-1:0] ins_q, ins_d, scan_q, scan_d;
  logic [NW:0]   steps_q, steps_d, head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [PW-1:0] pcnt_q, pcnt_d;
  logic [GA-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic          accept;
  logic [7:0]    fold;
  logic [NW-1:0] link;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cnt_q    <= (NW+1)'(1);
      ins_q    <= '0;
      pcnt_q   <= '0;
      scan_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      steps_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      ins_q    <= ins_d;
      pcnt_q   <= pcnt_d;
      scan_q   <= scan_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      steps_q  <= steps_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    c_q      <= c_d;
    last_q   <= last_d;
    status_q <= status_d;
    node_q   <= node_d;
    v_q      <= v_d;
    f_q      <= f_d;
    fu_q     <= fu_d;
    rsp_q    <= rsp_d;
  end

  always_comb begin
    fold = req_i.symbol;
    if (req_i.symbol >= 8'h41 && req_i.symbol <= 8'h5A) begin
      fold = req_i.symbol + 8'h20;
    end
    link = (g_rdata_q != '0 && g_rdata_q != v_q) ? g_rdata_q : '0;
  end

  always_comb begin
    state_d  = state_q;
    sym_d    = sym_q;
    c_d      = c_q;
    last_d   = last_q;
    status_d = status_q;
    node_d   = node_q;
    v_d      = v_q;
    f_d      = f_q;
    fu_d     = fu_q;
    ins_d    = ins_q;
    scan_d   = scan_q;
    steps_d  = steps_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    pcnt_d   = pcnt_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    rsp_d    = '0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d   = req_i.last_of_pattern;
          status_d = 1'b0;
          sym_d    = req_i.symbol[SB-1:0];
          unique case (req_i.command)
            CMD_ADD: begin
              sym_d   = fold[SB-1:0];
              state_d = ST_ADD_RD;
            end
            CMD_BUILD: begin
              head_d  = '0;
              tail_d  = '0;
              c_d     = '0;
              state_d = ST_BR_RD;
            end
            CMD_SCAN: begin
              node_d  = scan_q;
              steps_d = '0;
              state_d = ST_SCAN_RD;
            end
            CMD_RESTART: begin
              scan_d = '0;
              done_d = 1'b1;
            end
            CMD_CLEAR: begin
              cnt_d   = (NW+1)'(1);
              ins_d   = '0;
              pcnt_d  = '0;
              scan_d  = '0;
              clr_d   = '0;
              done_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        clr_d   = clr_q + GA'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_ADD_RD: begin
        g_raddr = {ins_q, sym_q};
        state_d = ST_ADD_G;
      end

      ST_ADD_G: begin
        state_d = ST_MARK_RD;
        if (g_rdata_q == '0 && cnt_q >= MaxCnt) begin
          status_d = 1'b1;
          node_d   = ins_q;
          if (last_q) begin
            ins_d = '0;
          end
        end else begin
          node_d = g_rdata_q;
          if (g_rdata_q == '0) begin
            node_d  = cnt_q[NW-1:0];
            cnt_d   = cnt_q + (NW+1)'(1);
            g_we    = 1'b1;
            g_waddr = {ins_q, sym_q};
            g_wdata = cnt_q[NW-1:0];
            f_we    = 1'b1;
            f_waddr = cnt_q[NW-1:0];
            m_we    = 1'b1;
            m_waddr = cnt_q[NW-1:0];
          end
          if (last_q) begin
            m_we    = 1'b1;
            m_waddr = (g_rdata_q == '0) ? cnt_q[NW-1:0] : g_rdata_q;
            m_wdata = {1'b1, pcnt_q};
            pcnt_d  = (pcnt_q == LastPat) ? '0 : pcnt_q + PW'(1);
            ins_d   = '0;
          end else begin
            ins_d = (g_rdata_q == '0) ? cnt_q[NW-1:0] : g_rdata_q;
          end
        end
      end

      ST_SCAN_RD: begin
        g_raddr = {node_q, sym_q};
        state_d = ST_SCAN_G;
      end

      ST_SCAN_G: begin
        if (g_rdata_q != '0) begin
          node_d  = g_rdata_q;
          scan_d  = g_rdata_q;
          state_d = ST_MARK_RD;
        end else if (node_q == '0) begin
          scan_d  = '0;
          state_d = ST_MARK_RD;
        end else if (steps_q >= MaxCnt) begin
          node_d  = '0;
          scan_d  = '0;
          state_d = ST_MARK_RD;
        end else begin
          f_raddr = node_q;
          state_d = ST_SCAN_F;
        end
      end

      ST_SCAN_F: begin
        node_d  = f_rdata_q;
        steps_d = steps_q + (NW+1)'(1);
        state_d = ST_SCAN_RD;
      end

      ST_MARK_RD: begin
        m_raddr = node_q;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        done_d              = 1'b1;
        rsp_d.current_node  = 8'(node_q);
        rsp_d.status        = status_q;
        if (node_q != '0 && m_rdata_q[PW]) begin
          rsp_d.is_match      = 1'b1;
          rsp_d.pattern_index = 8'(m_rdata_q[PW-1:0]);
        end
        state_d = ST_IDLE;
      end

      ST_BR_RD: begin
        g_raddr = {{NW{1'b0}}, c_q};
        state_d = ST_BR_G;
      end

      ST_BR_G: begin
        if (g_rdata_q != '0 && tail_q < MaxCnt) begin
          f_we    = 1'b1;
          f_waddr = g_rdata_q;
          q_we    = 1'b1;
          q_waddr = tail_q[NW-1:0];
          q_wdata = g_rdata_q;
          tail_d  = tail_q + (NW+1)'(1);
        end
        c_d     = c_q + SB'(1);
        state_d = (c_q == '1) ? ST_BQ_CHK : ST_BR_RD;
      end

      ST_BQ_CHK: begin
        if (head_q < tail_q) begin
          q_raddr = head_q[NW-1:0];
          head_d  = head_q + (NW+1)'(1);
          state_d = ST_BQ_U;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_BQ_U: begin
        node_d  = q_rdata_q;
        f_raddr = q_rdata_q;
        state_d = ST_BQ_FU;
      end

      ST_BQ_FU: begin
        fu_d    = f_rdata_q;
        c_d     = '0;
        state_d = ST_BC_RD;
      end

      ST_BC_RD: begin
        g_raddr = {node_q, c_q};
        state_d = ST_BC_V;
      end

      ST_BC_V: begin
        v_d = g_rdata_q;
        if (g_rdata_q == '0) begin
          c_d     = c_q + SB'(1);
          state_d = (c_q == '1) ? ST_BQ_CHK : ST_BC_RD;
        end else begin
          f_d     = fu_q;
          steps_d = '0;
          state_d = ST_BF_CHK;
        end
      end

      ST_BF_CHK: begin
        g_raddr = {f_q, c_q};
        state_d = ST_BF_G;
      end

      ST_BF_G: begin
        if (f_q != '0 && g_rdata_q == '0 && steps_q < MaxCnt) begin
          f_raddr = f_q;
          state_d = ST_BF_F;
        end else begin
          f_we    = 1'b1;
          f_waddr = v_q;
          f_wdata = link;
          if (tail_q < MaxCnt) begin
            q_we    = 1'b1;
            q_waddr = tail_q[NW-1:0];
            q_wdata = v_q;
            tail_d  = tail_q + (NW+1)'(1);
          end
          c_d     = c_q + SB'(1);
          state_d = (c_q == '1) ? ST_BQ_CHK : ST_BC_RD;
        end
      end

      ST_BF_F: begin
        f_d     = f_rdata_q;
        steps_d = steps_q + (NW+1)'(1);
        state_d = ST_BF_CHK;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= MaxCnt)
    else $error("node count out of range");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted transaction neither busy nor done");

  a_match_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.is_match) |-> rsp_o.pattern_index == 8'd0)
    else $error("pattern index without match");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= MaxCnt)
    else $error("failure chain step count overflow");

endmodule
